### rtl/sfr_pkg.sv
// Package for the sync frame receiver: receive state encoding, result kinds,
// frame constants and the byte-wide CRC-32 update function.
// No dependencies; imported by sync_frame_receiver_crc32_unit.
package sfr_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'h46;
  localparam logic [7:0]  SYNC_SECOND = 8'h43;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;

  // Receive phase: one state per header byte, then payload and trailer.
  typedef enum logic [3:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_VERSION,
    ST_FLAGS,
    ST_TYPE_LO,
    ST_TYPE_HI,
    ST_SEQ_LO,
    ST_SEQ_HI,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_PAYLOAD,
    ST_CRC
  } rx_state_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BAD_VER = 3'd2,
    KIND_BAD_LEN = 3'd3,
    KIND_BAD_CRC = 3'd4
  } kind_e;

  // Reflected CRC-32 update over one byte, LSB first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC register value right after the first sync byte.
  localparam logic [31:0] CRC_AFTER_SYNC = crc32_byte(CRC_ONES, SYNC_FIRST);

endpackage

### rtl/sync_frame_receiver_crc32_unit.sv
// Top level of the sync frame receiver: byte-serial deframer with CRC-32 check.
// Depends on sfr_pkg for state encoding, result kinds and the CRC function.
//
// This block takes one received byte per word on the input channel and
// deframes length-prefixed frames: sync pair 0x46 0x43, a version byte that
// must match the protocol_version register, a flags byte, and little-endian
// 16-bit type, sequence and payload length fields, followed by the payload and
// a little-endian CRC-32 (reflected 0xEDB88320, preset and final xor all ones)
// over all bytes from the first sync byte to the last payload byte. Each
// payload byte is delivered at once as a tentative result; the frame end
// delivers one good or error result, and the matching 32-bit wrapping counter
// advances. A receiver must discard tentative payload bytes of a frame that
// ends in an error. Bytes outside a frame produce no result. The block takes
// one byte every clock cycle while it is not stalled: a word passes an input
// register, and the combinational logic (the unrolled eight-step CRC byte
// update and the frame state machine) then writes the result register. The
// result register and the input register each hold one word, so the input
// register can still take a byte while a result waits to be taken, and the
// whole pipe stalls only while both are occupied. Counter and header outputs
// reflect the state at the time the presented result was produced. The user
// must write the version register through cfg_we_i only while the block is
// idle; the block itself does not enforce this.
module sync_frame_receiver_crc32_unit
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: protocol version register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input byte channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [8:0]  payload_index_o,
  output logic [7:0]  frame_flags_o,
  output logic [15:0] msg_type_o,
  output logic [15:0] seq_num_o,
  output logic [9:0]  payload_len_o,
  output logic [31:0] good_frames_o,
  output logic [31:0] crc_errors_o,
  output logic [31:0] length_errors_o,
  output logic [31:0] version_errors_o
);

  // Length storage is wide enough for MAX_PAYLOAD and for the 10-bit output.
  localparam int unsigned LenBits = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned LenW    = (LenBits > 10) ? LenBits : 10;
  localparam logic [15:0] MaxLen  = 16'(MAX_PAYLOAD);

  // Input register stage.
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s2_adv;
  logic        proc;

  // Frame state.
  rx_state_e   state_q, state_d;
  logic [7:0]  version_q;
  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_upd;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] type_q, type_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [LenW-1:0] len_q, len_d;
  logic [15:0] len_full;
  logic        len_bad;
  logic [LenW-1:0] pay_cnt_q, pay_cnt_d;
  logic [LenW-1:0] pay_cnt_inc;
  logic [1:0]  crc_cnt_q, crc_cnt_d;
  logic [23:0] crc_rx_q, crc_rx_d;
  logic        crc_match;

  // Counters.
  logic [31:0] good_q, good_d;
  logic [31:0] crc_err_q, crc_err_d;
  logic [31:0] len_err_q, len_err_d;
  logic [31:0] ver_err_q, ver_err_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [8:0]  pidx_q, pidx_d;
  logic        res_valid;

  // A stage moves forward whenever the result register is free or is being
  // emptied in this cycle.
  assign s2_adv     = !out_valid_q || out_ready_i;
  assign proc       = s1_valid_q && s2_adv;
  assign in_ready_o = !s1_valid_q || s2_adv;

  assign crc_upd     = crc32_byte(crc_q, s1_byte_q);
  assign len_full    = {s1_byte_q, len_lo_q};
  assign len_bad     = len_full > MaxLen;
  assign pay_cnt_inc = pay_cnt_q + LenW'(1);
  assign crc_match   = ({s1_byte_q, crc_rx_q} == ~crc_q);

  // Next receive state.
  always_comb begin
    state_d = state_q;
    if (proc) begin
      unique case (state_q)
        ST_HUNT: begin
          if (s1_byte_q == SYNC_FIRST) state_d = ST_SYNC2;
        end
        ST_SYNC2: begin
          if (s1_byte_q == SYNC_SECOND) begin
            state_d = ST_VERSION;
          end else if (s1_byte_q != SYNC_FIRST) begin
            state_d = ST_HUNT;
          end
        end
        ST_VERSION: begin
          state_d = (s1_byte_q == version_q) ? ST_FLAGS : ST_HUNT;
        end
        ST_FLAGS:   state_d = ST_TYPE_LO;
        ST_TYPE_LO: state_d = ST_TYPE_HI;
        ST_TYPE_HI: state_d = ST_SEQ_LO;
        ST_SEQ_LO:  state_d = ST_SEQ_HI;
        ST_SEQ_HI:  state_d = ST_LEN_LO;
        ST_LEN_LO:  state_d = ST_LEN_HI;
        ST_LEN_HI: begin
          if (len_bad) begin
            state_d = ST_HUNT;
          end else if (len_full == 16'd0) begin
            state_d = ST_CRC;
          end else begin
            state_d = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          if (pay_cnt_inc == len_q) state_d = ST_CRC;
        end
        ST_CRC: begin
          if (crc_cnt_q == 2'd3) state_d = ST_HUNT;
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  // Datapath, counters and result generation.
  always_comb begin
    crc_d     = crc_q;
    flags_d   = flags_q;
    type_d    = type_q;
    seq_d     = seq_q;
    len_lo_d  = len_lo_q;
    len_d     = len_q;
    pay_cnt_d = pay_cnt_q;
    crc_cnt_d = crc_cnt_q;
    crc_rx_d  = crc_rx_q;
    good_d    = good_q;
    crc_err_d = crc_err_q;
    len_err_d = len_err_q;
    ver_err_d = ver_err_q;
    res_valid = 1'b0;
    kind_d    = KIND_PAYLOAD;
    pbyte_d   = 8'd0;
    pidx_d    = 9'd0;
    if (proc) begin
      unique case (state_q)
        ST_HUNT: begin
          crc_d = CRC_AFTER_SYNC;
        end
        ST_SYNC2: begin
          // A repeated first sync byte restarts the CRC from that byte.
          crc_d = (s1_byte_q == SYNC_SECOND) ? crc_upd : CRC_AFTER_SYNC;
        end
        ST_VERSION: begin
          crc_d = crc_upd;
          if (s1_byte_q != version_q) begin
            ver_err_d = ver_err_q + 32'd1;
            res_valid = 1'b1;
            kind_d    = KIND_BAD_VER;
          end
        end
        ST_FLAGS: begin
          crc_d   = crc_upd;
          flags_d = s1_byte_q;
        end
        ST_TYPE_LO: begin
          crc_d  = crc_upd;
          type_d = {8'd0, s1_byte_q};
        end
        ST_TYPE_HI: begin
          crc_d  = crc_upd;
          type_d = {s1_byte_q, type_q[7:0]};
        end
        ST_SEQ_LO: begin
          crc_d = crc_upd;
          seq_d = {8'd0, s1_byte_q};
        end
        ST_SEQ_HI: begin
          crc_d = crc_upd;
          seq_d = {s1_byte_q, seq_q[7:0]};
        end
        ST_LEN_LO: begin
          crc_d    = crc_upd;
          len_lo_d = s1_byte_q;
        end
        ST_LEN_HI: begin
          crc_d     = crc_upd;
          len_d     = LenW'(len_full);
          pay_cnt_d = '0;
          crc_cnt_d = 2'd0;
          if (len_bad) begin
            len_err_d = len_err_q + 32'd1;
            res_valid = 1'b1;
            kind_d    = KIND_BAD_LEN;
          end
        end
        ST_PAYLOAD: begin
          crc_d     = crc_upd;
          pay_cnt_d = pay_cnt_inc;
          res_valid = 1'b1;
          kind_d    = KIND_PAYLOAD;
          pbyte_d   = s1_byte_q;
          pidx_d    = pay_cnt_q[8:0];
        end
        ST_CRC: begin
          // Trailer bytes arrive least significant first.
          case (crc_cnt_q)
            2'd0:    crc_rx_d[7:0]   = s1_byte_q;
            2'd1:    crc_rx_d[15:8]  = s1_byte_q;
            2'd2:    crc_rx_d[23:16] = s1_byte_q;
            default: crc_rx_d        = crc_rx_q;
          endcase
          crc_cnt_d = crc_cnt_q + 2'd1;
          if (crc_cnt_q == 2'd3) begin
            res_valid = 1'b1;
            if (crc_match) begin
              good_d = good_q + 32'd1;
              kind_d = KIND_GOOD;
            end else begin
              crc_err_d = crc_err_q + 32'd1;
              kind_d    = KIND_BAD_CRC;
            end
          end
        end
        default: begin
          crc_d = CRC_ONES;
        end
      endcase
    end
  end

  always_comb begin
    if (proc) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= ST_HUNT;
      version_q   <= 8'd1;
      crc_cnt_q   <= 2'd0;
      good_q      <= '0;
      crc_err_q   <= '0;
      len_err_q   <= '0;
      ver_err_q   <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_PAYLOAD;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (proc) begin
        s1_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        version_q <= cfg_wdata_i;
      end
      state_q     <= state_d;
      crc_cnt_q   <= crc_cnt_d;
      good_q      <= good_d;
      crc_err_q   <= crc_err_d;
      len_err_q   <= len_err_d;
      ver_err_q   <= ver_err_d;
      out_valid_q <= out_valid_d;
      if (proc) begin
        kind_q <= kind_d;
      end
    end
  end

  // Payload and header registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
    crc_q     <= crc_d;
    flags_q   <= flags_d;
    type_q    <= type_d;
    seq_q     <= seq_d;
    len_lo_q  <= len_lo_d;
    len_q     <= len_d;
    pay_cnt_q <= pay_cnt_d;
    crc_rx_q  <= crc_rx_d;
    if (proc) begin
      pbyte_q <= pbyte_d;
      pidx_q  <= pidx_d;
    end
  end

  // Frame state only changes while a result can be written, so the header
  // and counter registers still match the presented result.
  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign payload_byte_o   = pbyte_q;
  assign payload_index_o  = pidx_q;
  assign frame_flags_o    = (kind_q == KIND_GOOD) ? flags_q : 8'd0;
  assign msg_type_o       = (kind_q == KIND_GOOD) ? type_q : 16'd0;
  assign seq_num_o        = (kind_q == KIND_GOOD) ? seq_q : 16'd0;
  assign payload_len_o    = (kind_q == KIND_GOOD) ? len_q[9:0] : 10'd0;
  assign good_frames_o    = good_q;
  assign crc_errors_o     = crc_err_q;
  assign length_errors_o  = len_err_q;
  assign version_errors_o = ver_err_q;

`ifndef ASSERT_OFF
  // The payload counter stays below the stored length inside the payload.
  a_pay_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAYLOAD) |-> (pay_cnt_q < len_q))
    else $error("payload counter reached frame length");

  // The trailer byte counter is idle outside the trailer.
  a_crc_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CRC) |-> (crc_cnt_q == 2'd0))
    else $error("trailer counter active outside trailer");

  // A good-frame result advances the good counter by exactly one.
  a_good_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && res_valid && (kind_d == KIND_GOOD)) |=>
      (good_q == $past(good_q) + 32'd1))
    else $error("good counter did not advance");

  // A stalled result freezes the frame state.
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(state_q))
    else $error("state advanced while result stalled");
`endif

endmodule

### dv/sync_frame_receiver_crc32_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sync_frame_receiver_crc32_unit: a byte driver, a result
// monitor and a byte-level predictor of the deframer. Depends on sfr_pkg for kind_e.
module sync_frame_receiver_crc32_unit_tb
  import sfr_pkg::*;
();

  // Frame layout as seen on the wire.
  localparam logic [7:0]  SYNC_A      = 8'h46;
  localparam logic [7:0]  SYNC_B      = 8'h43;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_REV     = 32'hEDB8_8320;
  localparam int unsigned HDR_BYTES   = 10;
  localparam int unsigned CRC_BYTES   = 4;
  localparam int unsigned MAX_LEN     = 512;
  localparam int unsigned OFS_VERSION = 2;
  localparam int unsigned OFS_FLAGS   = 3;
  localparam int unsigned OFS_TYPE_LO = 4;
  localparam int unsigned OFS_TYPE_HI = 5;
  localparam int unsigned OFS_SEQ_LO  = 6;
  localparam int unsigned OFS_SEQ_HI  = 7;
  localparam int unsigned OFS_LEN_LO  = 8;
  localparam int unsigned OFS_LEN_HI  = 9;

  // Timing of the bench. A taken byte passes the input register and then the
  // result register, so a few spare cycles cover a byte that produces no result at all.
  localparam int LAT_SLACK   = 4;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  // How a generated frame is damaged, if at all.
  typedef enum {
    FRAME_OK,
    FRAME_BAD_CRC,
    FRAME_CUT_VERSION,
    FRAME_CUT_HEADER
  } frame_fault_e;

  typedef struct {
    kind_e       kind;
    logic [7:0]  pbyte;
    logic [8:0]  pidx;
    logic [7:0]  flags;
    logic [15:0] mtype;
    logic [15:0] seq;
    logic [9:0]  plen;
    logic [31:0] good;
    logic [31:0] crc_err;
    logic [31:0] len_err;
    logic [31:0] ver_err;
  } rx_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [8:0]  payload_index_o;
  logic [7:0]  frame_flags_o;
  logic [15:0] msg_type_o;
  logic [15:0] seq_num_o;
  logic [9:0]  payload_len_o;
  logic [31:0] good_frames_o;
  logic [31:0] crc_errors_o;
  logic [31:0] length_errors_o;
  logic [31:0] version_errors_o;

  sync_frame_receiver_crc32_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .frame_flags_o    (frame_flags_o),
    .msg_type_o       (msg_type_o),
    .seq_num_o        (seq_num_o),
    .payload_len_o    (payload_len_o),
    .good_frames_o    (good_frames_o),
    .crc_errors_o     (crc_errors_o),
    .length_errors_o  (length_errors_o),
    .version_errors_o (version_errors_o)
  );

  // Bytes still to be sent, and the results that the bytes already taken must produce.
  logic [7:0]  rx_stream[$];
  rx_result_t  rx_results_due[$];
  int unsigned bytes_queued;

  // Predictor state: a private copy of the deframer's registers and counters.
  int unsigned frame_pos;
  logic [7:0]  fr_flags;
  logic [15:0] fr_type;
  logic [15:0] fr_seq;
  logic [15:0] fr_len;
  logic [31:0] crc_acc;
  logic [31:0] crc_got;
  logic [31:0] cnt_good;
  logic [31:0] cnt_crc;
  logic [31:0] cnt_len;
  logic [31:0] cnt_ver;
  logic [7:0]  proto_ver;

  // Handshake bookkeeping shared between the clocked processes.
  logic byte_taken;
  logic long_hold_req;
  int   hold_left;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_cycles;
  int   mismatch_count;

  // Reflected CRC-32, fed one data bit at a time from the least significant end.
  function automatic logic [31:0] crc32_advance(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ ((r[0] ^ d[k]) ? CRC_REV : 32'h0);
    end
    return r;
  endfunction

  // Builds one expected result from the current counters and, for a good frame,
  // the header fields of the frame that just ended.
  function automatic rx_result_t make_result(input kind_e k, input logic [7:0] pb,
                                             input logic [8:0] pi, input logic with_hdr);
    rx_result_t r;
    r.kind    = k;
    r.pbyte   = pb;
    r.pidx    = pi;
    r.flags   = with_hdr ? fr_flags : 8'h00;
    r.mtype   = with_hdr ? fr_type : 16'h0000;
    r.seq     = with_hdr ? fr_seq : 16'h0000;
    r.plen    = with_hdr ? fr_len[9:0] : 10'h000;
    r.good    = cnt_good;
    r.crc_err = cnt_crc;
    r.len_err = cnt_len;
    r.ver_err = cnt_ver;
    return r;
  endfunction

  function automatic void restart_hunt();
    frame_pos = 0;
    crc_acc   = CRC_INIT;
    crc_got   = 32'h0;
  endfunction

  // Advances the predicted deframer by one accepted byte and records any result
  // that the byte causes.
  task automatic deframe_byte(input logic [7:0] b);
    int unsigned pos;
    int unsigned pay_end;
    pos = frame_pos;
    if (pos == 0) begin
      if (b == SYNC_A) begin
        crc_acc   = crc32_advance(CRC_INIT, b);
        frame_pos = 1;
      end
    end else if (pos == 1) begin
      // A second 0x46 is taken as a fresh first sync byte.
      if (b == SYNC_B) begin
        crc_acc   = crc32_advance(crc_acc, b);
        frame_pos = 2;
      end else if (b == SYNC_A) begin
        crc_acc = crc32_advance(CRC_INIT, b);
      end else begin
        restart_hunt();
      end
    end else if (pos < HDR_BYTES) begin
      crc_acc   = crc32_advance(crc_acc, b);
      frame_pos = pos + 1;
      case (pos)
        OFS_VERSION: begin
          if (b != proto_ver) begin
            cnt_ver++;
            restart_hunt();
            rx_results_due.push_back(make_result(KIND_BAD_VER, 8'h00, 9'h000, 1'b0));
          end
        end
        OFS_FLAGS:   fr_flags = b;
        OFS_TYPE_LO: fr_type = {8'h00, b};
        OFS_TYPE_HI: fr_type[15:8] = b;
        OFS_SEQ_LO:  fr_seq = {8'h00, b};
        OFS_SEQ_HI:  fr_seq[15:8] = b;
        OFS_LEN_LO:  fr_len = {8'h00, b};
        default: begin
          fr_len[15:8] = b;
          crc_got = 32'h0;
          if (fr_len > MAX_LEN) begin
            cnt_len++;
            restart_hunt();
            rx_results_due.push_back(make_result(KIND_BAD_LEN, 8'h00, 9'h000, 1'b0));
          end
        end
      endcase
    end else begin
      pay_end = HDR_BYTES + fr_len;
      if (pos < pay_end) begin
        crc_acc   = crc32_advance(crc_acc, b);
        frame_pos = pos + 1;
        rx_results_due.push_back(make_result(KIND_PAYLOAD, b, 9'(pos - HDR_BYTES), 1'b0));
      end else begin
        // Trailer bytes arrive least significant first.
        crc_got   = crc_got | ({24'h0, b} << (8 * ((pos - pay_end) & 3)));
        frame_pos = pos + 1;
        if (pos - pay_end + 1 >= CRC_BYTES) begin
          if ((crc_acc ^ CRC_INIT) == crc_got) begin
            cnt_good++;
            restart_hunt();
            rx_results_due.push_back(make_result(KIND_GOOD, 8'h00, 9'h000, 1'b1));
          end else begin
            cnt_crc++;
            restart_hunt();
            rx_results_due.push_back(make_result(KIND_BAD_CRC, 8'h00, 9'h000, 1'b0));
          end
        end
      end
    end
  endtask

  function automatic void push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endfunction

  // Queues one frame with random payload. Frames with a wrong version or an
  // oversized length stop where the block gives up on them.
  task automatic queue_frame(input logic [7:0] ver, input logic [7:0] flags,
                             input logic [15:0] mtype, input logic [15:0] seq,
                             input logic [15:0] len, input frame_fault_e fault);
    logic [7:0]  fb[$];
    logic [31:0] crc;
    logic [31:0] flip;
    fb.push_back(SYNC_A);
    fb.push_back(SYNC_B);
    fb.push_back(ver);
    if (fault != FRAME_CUT_VERSION) begin
      fb.push_back(flags);
      fb.push_back(mtype[7:0]);
      fb.push_back(mtype[15:8]);
      fb.push_back(seq[7:0]);
      fb.push_back(seq[15:8]);
      fb.push_back(len[7:0]);
      fb.push_back(len[15:8]);
    end
    if (fault == FRAME_OK || fault == FRAME_BAD_CRC) begin
      for (int i = 0; i < len; i++) begin
        fb.push_back(8'($urandom_range(255)));
      end
      crc = CRC_INIT;
      foreach (fb[i]) begin
        crc = crc32_advance(crc, fb[i]);
      end
      crc = crc ^ CRC_INIT;
      if (fault == FRAME_BAD_CRC) begin
        flip = $urandom;
        if (flip == 32'h0) begin
          flip = 32'h1;
        end
        crc = crc ^ flip;
      end
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
      fb.push_back(crc[23:16]);
      fb.push_back(crc[31:24]);
    end
    foreach (fb[i]) begin
      push_byte(fb[i]);
    end
  endtask

  // Mostly well-formed frames with random header and payload content, mixed with
  // damaged frames, repeated sync bytes, aborted syncs and line noise.
  task automatic random_batch(input int unsigned n_bytes);
    int unsigned start;
    int          pick;
    int unsigned len;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(19) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
      if (pick < 60) begin
        queue_frame(proto_ver, 8'($urandom), 16'($urandom), 16'($urandom),
                    16'(len), FRAME_OK);
      end else if (pick < 70) begin
        queue_frame(proto_ver, 8'($urandom), 16'($urandom), 16'($urandom),
                    16'(len), FRAME_BAD_CRC);
      end else if (pick < 77) begin
        queue_frame(proto_ver ^ 8'($urandom_range(1, 255)), 8'h00, 16'h0, 16'h0,
                    16'h0, FRAME_CUT_VERSION);
      end else if (pick < 84) begin
        queue_frame(proto_ver, 8'($urandom), 16'($urandom), 16'($urandom),
                    ($urandom_range(1) == 0) ? 16'(MAX_LEN + 1)
                                             : 16'($urandom_range(MAX_LEN + 1, 65535)),
                    FRAME_CUT_HEADER);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) push_byte(SYNC_A);
        queue_frame(proto_ver, 8'($urandom), 16'($urandom), 16'($urandom),
                    16'(len), FRAME_OK);
      end else if (pick < 95) begin
        // A first sync byte followed by anything but a sync byte.
        push_byte(SYNC_A);
        push_byte(8'($urandom_range(0, 8'h42)));
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Holds the sender back until every queued byte is taken and every expected
  // result has come out, then lets the pipeline run empty.
  task automatic wait_idle();
    while (rx_stream.size() != 0 || in_valid_i || rx_results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (LAT_SLACK) @(posedge clk_i);
  endtask

  task automatic set_version(input logic [7:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    proto_ver = v;
    @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sender: a new word is offered at a falling edge only once the previous one
  // has been taken, and then stays put until the block takes it.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      byte_taken = 1'b0;
      if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_byte_i  <= rx_stream.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request that lets the
  // input and result registers fill so that the block backs up its input.
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: results are checked before the byte taken at the same edge is
  // predicted; that byte cannot affect a result already on the port.
  always @(posedge clk_i) begin : result_check
    rx_result_t want;
    logic       moved;
    logic       bad;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (rx_results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: result with none expected: kind %0d byte %h idx %0d",
                     $time, kind_o, payload_byte_o, payload_index_o);
          end
        end else begin
          want = rx_results_due.pop_front();
          bad  = (kind_o !== want.kind) || (payload_byte_o !== want.pbyte) ||
                 (payload_index_o !== want.pidx) || (frame_flags_o !== want.flags) ||
                 (msg_type_o !== want.mtype) || (seq_num_o !== want.seq) ||
                 (payload_len_o !== want.plen) || (good_frames_o !== want.good) ||
                 (crc_errors_o !== want.crc_err) || (length_errors_o !== want.len_err) ||
                 (version_errors_o !== want.ver_err);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("%0t: mismatch exp/got kind %0d/%0d byte %h/%h idx %0d/%0d",
                       $time, want.kind, kind_o, want.pbyte, payload_byte_o,
                       want.pidx, payload_index_o);
              $display("  flags %h/%h type %h/%h seq %h/%h len %0d/%0d",
                       want.flags, frame_flags_o, want.mtype, msg_type_o,
                       want.seq, seq_num_o, want.plen, payload_len_o);
              $display("  counters %0d %0d %0d %0d / %0d %0d %0d %0d",
                       want.good, want.crc_err, want.len_err, want.ver_err,
                       good_frames_o, crc_errors_o, length_errors_o, version_errors_o);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved      = 1'b1;
        byte_taken = 1'b1;
        deframe_byte(rx_byte_i);
      end
      // Watchdog: too long without any word moving on either side.
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("[sync_frame_receiver_crc32_unit] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 8'h00;
    in_valid_i     = 1'b0;
    rx_byte_i      = 8'h00;
    out_ready_i    = 1'b0;
    byte_taken     = 1'b0;
    long_hold_req  = 1'b0;
    hold_left      = 0;
    stall_cycles   = 0;
    mismatch_count = 0;
    bytes_queued   = 0;
    send_idle_pct  = 7;
    recv_idle_pct  = 79;
    fr_flags       = 8'h00;
    fr_type        = 16'h0;
    fr_seq         = 16'h0;
    fr_len         = 16'h0;
    cnt_good       = 32'h0;
    cnt_crc        = 32'h0;
    cnt_len        = 32'h0;
    cnt_ver        = 32'h0;
    proto_ver      = 8'd1;
    restart_hunt();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed part at the reset version: bytes dropped while hunting, a sync
    // byte followed by junk, a repeated first sync byte in front of a
    // zero-length frame with all-ones flags and type fields, a wrong version, and a
    // length just above the maximum.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SYNC_A);
    push_byte(8'h2A);
    push_byte(SYNC_A);
    queue_frame(proto_ver, 8'hFF, 16'hFFFF, 16'h0000, 16'h0000, FRAME_OK);
    queue_frame(8'hFE, 8'h00, 16'h0, 16'h0, 16'h0, FRAME_CUT_VERSION);
    queue_frame(proto_ver, 8'h00, 16'h0000, 16'hFFFF, 16'(MAX_LEN + 1), FRAME_CUT_HEADER);

    // Lowest version, sender mostly busy and receiver mostly stalled.
    set_version(8'h00);
    random_batch(130);

    // Highest version, the other way round.
    set_version(8'hFF);
    send_idle_pct = 79;
    recv_idle_pct = 7;
    random_batch(130);

    // A middle version with no idling at all. The receiver first holds off for a
    // long stretch while the sender keeps offering words.
    set_version(8'($urandom_range(2, 254)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    random_batch(140);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && rx_results_due.size() == 0) begin
      $display("[sync_frame_receiver_crc32_unit] OK");
    end else begin
      $display("[sync_frame_receiver_crc32_unit] ERROR");
    end
    $finish;
  end

endmodule
